[rtl/cpcm_pkg.sv]
// Shared types and constants for the circle pair collision unit.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps
package cpcm_pkg;
   localparam int MASK_BITS = 16;
   localparam int POS_W = 24;
   localparam int DIFF_W = 25;
   localparam int RAD_W = 16;
   localparam int RS_W = 17;
   localparam int D2_W = 51;
   localparam int SQ_IN_W = 34;
   localparam int FINE_SHIFT = 28;
   localparam int ROOT_W = 31;
   localparam int SQRT_STAGES = 31;
   localparam int ABS_W = 17;
   localparam int Q_W = 15;
   localparam int NUM_W = ABS_W + FINE_SHIFT + 1;
   localparam int PEN_W = 17;
   localparam int NORM_W = 16;
   localparam logic [NORM_W-1:0] NORM_ONE = 16'd16384;
   // Front end 3, root 31, divider 16, output register 1.
   localparam int LATENCY = 3 + SQRT_STAGES + Q_W + 1 + 1;

   typedef struct packed {
      logic              hit;
      logic              zero;
      logic [RS_W-1:0]   rs;
      logic [RAD_W-1:0]  ar;
      logic [ABS_W-1:0]  adx;
      logic [ABS_W-1:0]  ady;
      logic              neg_x;
      logic              neg_y;
   } side_type;
endpackage

[rtl/cpcm_front.sv]
// Front end: differences, squares and the overlap test, three register stages.
// Depends on cpcm_pkg.
`timescale 1ns / 1ps
module cpcm_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   input  logic signed [cpcm_pkg::POS_W-1:0]  a_x,
   input  logic signed [cpcm_pkg::POS_W-1:0]  a_y,
   input  logic [cpcm_pkg::RAD_W-1:0]         a_r,
   input  logic [cpcm_pkg::MASK_BITS-1:0]     a_m,
   input  logic signed [cpcm_pkg::POS_W-1:0]  b_x,
   input  logic signed [cpcm_pkg::POS_W-1:0]  b_y,
   input  logic [cpcm_pkg::RAD_W-1:0]         b_r,
   input  logic [cpcm_pkg::MASK_BITS-1:0]     b_m,
   output logic                               out_valid,
   output logic [cpcm_pkg::SQ_IN_W-1:0]       d2_out,
   output cpcm_pkg::side_type                 side_out
);
   // Stage 1
   logic v1_ff, v1_in;
   logic signed [cpcm_pkg::DIFF_W-1:0] dx1_ff, dx1_in, dy1_ff, dy1_in;
   logic [cpcm_pkg::RS_W-1:0] rs1_ff, rs1_in;
   logic [cpcm_pkg::RAD_W-1:0] ar1_ff;
   logic excl1_ff, excl1_in;
   // Stage 2
   logic v2_ff;
   logic [2*cpcm_pkg::DIFF_W-1:0] sx2_ff, sx2_in, sy2_ff, sy2_in;
   logic [2*cpcm_pkg::RS_W-1:0] rr2_ff, rr2_in;
   logic [cpcm_pkg::DIFF_W-1:0] adx2_ff, adx2_in, ady2_ff, ady2_in;
   logic nx2_ff, ny2_ff, excl2_ff;
   logic [cpcm_pkg::RS_W-1:0] rs2_ff;
   logic [cpcm_pkg::RAD_W-1:0] ar2_ff;
   // Stage 3
   logic v3_ff;
   logic [cpcm_pkg::D2_W-1:0] d2_sum;
   logic [cpcm_pkg::SQ_IN_W-1:0] d2_3_ff;
   cpcm_pkg::side_type side3_ff, side3_in;

   assign v1_in = in_valid;
   assign dx1_in = cpcm_pkg::DIFF_W'(a_x) - cpcm_pkg::DIFF_W'(b_x);
   assign dy1_in = cpcm_pkg::DIFF_W'(a_y) - cpcm_pkg::DIFF_W'(b_y);
   assign rs1_in = {1'b0, a_r} + {1'b0, b_r};
   assign excl1_in = |(a_m & b_m);

   assign adx2_in = dx1_ff[cpcm_pkg::DIFF_W-1] ? -dx1_ff : dx1_ff;
   assign ady2_in = dy1_ff[cpcm_pkg::DIFF_W-1] ? -dy1_ff : dy1_ff;
   assign sx2_in = {{cpcm_pkg::DIFF_W{1'b0}}, adx2_in} * {{cpcm_pkg::DIFF_W{1'b0}}, adx2_in};
   assign sy2_in = {{cpcm_pkg::DIFF_W{1'b0}}, ady2_in} * {{cpcm_pkg::DIFF_W{1'b0}}, ady2_in};
   assign rr2_in = {{cpcm_pkg::RS_W{1'b0}}, rs1_ff} * {{cpcm_pkg::RS_W{1'b0}}, rs1_ff};

   assign d2_sum = {1'b0, sx2_ff} + {1'b0, sy2_ff};

   always_comb begin
      side3_in.hit = !excl2_ff && (d2_sum <= {{(cpcm_pkg::D2_W-2*cpcm_pkg::RS_W){1'b0}}, rr2_ff});
      side3_in.zero = (d2_sum == '0);
      side3_in.rs = rs2_ff;
      side3_in.ar = ar2_ff;
      side3_in.adx = adx2_ff[cpcm_pkg::ABS_W-1:0];
      side3_in.ady = ady2_ff[cpcm_pkg::ABS_W-1:0];
      side3_in.neg_x = nx2_ff;
      side3_in.neg_y = ny2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      dx1_ff <= dx1_in;
      dy1_ff <= dy1_in;
      rs1_ff <= rs1_in;
      ar1_ff <= a_r;
      excl1_ff <= excl1_in;
      sx2_ff <= sx2_in;
      sy2_ff <= sy2_in;
      rr2_ff <= rr2_in;
      adx2_ff <= adx2_in;
      ady2_ff <= ady2_in;
      // A positive difference means b lies below a, so that normal is negative.
      nx2_ff <= !dx1_ff[cpcm_pkg::DIFF_W-1] && (dx1_ff != '0);
      ny2_ff <= !dy1_ff[cpcm_pkg::DIFF_W-1] && (dy1_ff != '0);
      excl2_ff <= excl1_ff;
      rs2_ff <= rs1_ff;
      ar2_ff <= ar1_ff;
      d2_3_ff <= d2_sum[cpcm_pkg::SQ_IN_W-1:0];
      side3_ff <= side3_in;
   end

   assign out_valid = v3_ff;
   assign d2_out = d2_3_ff;
   assign side_out = side3_ff;
endmodule

[rtl/cpcm_sqrt.sv]
// Pipelined bit-by-bit integer square root of d2 shifted up by the fine scale.
// One root bit per register stage. Depends on cpcm_pkg.
`timescale 1ns / 1ps
module cpcm_sqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [cpcm_pkg::SQ_IN_W-1:0]   d2_in,
   input  cpcm_pkg::side_type             side_in,
   output logic                           out_valid,
   output logic [cpcm_pkg::ROOT_W-1:0]    root_out,
   output cpcm_pkg::side_type             side_out
);
   localparam int N = cpcm_pkg::SQRT_STAGES;
   localparam int VW = cpcm_pkg::SQ_IN_W + cpcm_pkg::FINE_SHIFT;

   logic                          v_ff    [0:N-1];
   logic [cpcm_pkg::SQ_IN_W-1:0]  d2_ff   [0:N-1];
   logic [31:0]                   rem_ff  [0:N-1];
   logic [cpcm_pkg::ROOT_W-1:0]   root_ff [0:N-1];
   cpcm_pkg::side_type            side_ff [0:N-1];

   for (genvar k = 0; k < N; k++) begin : g_step
      localparam int HI = VW - 1 - 2 * k;
      logic                          v_p;
      logic [cpcm_pkg::SQ_IN_W-1:0]  d2_p;
      logic [31:0]                   rem_p;
      logic [cpcm_pkg::ROOT_W-1:0]   root_p;
      cpcm_pkg::side_type            side_p;
      logic [VW-1:0]                 v_word;
      logic [33:0]                   rem_sh, trial;
      logic [31:0]                   rem_in;
      logic [cpcm_pkg::ROOT_W-1:0]   root_in;

      if (k == 0) begin : g_first
         assign v_p = in_valid;
         assign d2_p = d2_in;
         assign rem_p = '0;
         assign root_p = '0;
         assign side_p = side_in;
      end else begin : g_next
         assign v_p = v_ff[k-1];
         assign d2_p = d2_ff[k-1];
         assign rem_p = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      assign v_word = {d2_p, {cpcm_pkg::FINE_SHIFT{1'b0}}};
      assign rem_sh = {rem_p, v_word[HI -: 2]};
      assign trial = {1'b0, root_p, 2'b01};

      always_comb begin
         if (rem_sh >= trial) begin
            rem_in = 32'(rem_sh - trial);
            root_in = {root_p[cpcm_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            root_in = {root_p[cpcm_pkg::ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_p;
         end
         d2_ff[k] <= d2_p;
         rem_ff[k] <= rem_in;
         root_ff[k] <= root_in;
         side_ff[k] <= side_p;
      end
   end

   assign out_valid = v_ff[N-1];
   assign root_out = root_ff[N-1];
   assign side_out = side_ff[N-1];
endmodule

[rtl/cpcm_div.sv]
// Two-lane pipelined restoring divider for the normal components, one quotient
// bit per stage, rounding to nearest. Depends on cpcm_pkg.
`timescale 1ns / 1ps
module cpcm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [cpcm_pkg::ROOT_W-1:0]   fine_in,
   input  cpcm_pkg::side_type            side_in,
   output logic                          out_valid,
   output logic [cpcm_pkg::ROOT_W-1:0]   fine_out,
   output logic [cpcm_pkg::Q_W-1:0]      qx_out,
   output logic [cpcm_pkg::Q_W-1:0]      qy_out,
   output cpcm_pkg::side_type            side_out
);
   localparam int N = cpcm_pkg::Q_W + 1;
   localparam int NW = cpcm_pkg::NUM_W;
   localparam int QW = cpcm_pkg::Q_W;

   logic                          v_ff    [0:N-1];
   logic [cpcm_pkg::ROOT_W-1:0]   f_ff    [0:N-1];
   logic [cpcm_pkg::ROOT_W-1:0]   rx_ff   [0:N-1];
   logic [cpcm_pkg::ROOT_W-1:0]   ry_ff   [0:N-1];
   logic [NW-1:0]                 nx_ff   [0:N-1];
   logic [NW-1:0]                 ny_ff   [0:N-1];
   cpcm_pkg::side_type            side_ff [0:N-1];

   logic [NW-1:0] nx_in, ny_in;
   logic [NW-1:0] half;

   // The quotient never exceeds one in Q1.14, so the top part of the
   // numerator already sits below the divisor and seeds the remainder.
   assign half = NW'(fine_in >> 1);
   assign nx_in = {1'b0, side_in.adx, {cpcm_pkg::FINE_SHIFT{1'b0}}} + half;
   assign ny_in = {1'b0, side_in.ady, {cpcm_pkg::FINE_SHIFT{1'b0}}} + half;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= in_valid;
      end
      f_ff[0] <= fine_in;
      rx_ff[0] <= cpcm_pkg::ROOT_W'(nx_in >> QW);
      ry_ff[0] <= cpcm_pkg::ROOT_W'(ny_in >> QW);
      nx_ff[0] <= nx_in;
      ny_ff[0] <= ny_in;
      side_ff[0] <= side_in;
   end

   for (genvar k = 1; k < N; k++) begin : g_step
      localparam int BIT = QW - k;
      logic [cpcm_pkg::ROOT_W:0]    shx, shy;
      logic [cpcm_pkg::ROOT_W-1:0]  rx_in, ry_in;
      logic [NW-1:0]                qx_in, qy_in;

      assign shx = {rx_ff[k-1], nx_ff[k-1][BIT]};
      assign shy = {ry_ff[k-1], ny_ff[k-1][BIT]};

      always_comb begin
         qx_in = nx_ff[k-1];
         qy_in = ny_ff[k-1];
         if (shx >= {1'b0, f_ff[k-1]}) begin
            rx_in = cpcm_pkg::ROOT_W'(shx - {1'b0, f_ff[k-1]});
            qx_in[BIT] = 1'b1;
         end else begin
            rx_in = shx[cpcm_pkg::ROOT_W-1:0];
            qx_in[BIT] = 1'b0;
         end
         if (shy >= {1'b0, f_ff[k-1]}) begin
            ry_in = cpcm_pkg::ROOT_W'(shy - {1'b0, f_ff[k-1]});
            qy_in[BIT] = 1'b1;
         end else begin
            ry_in = shy[cpcm_pkg::ROOT_W-1:0];
            qy_in[BIT] = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else begin
            v_ff[k] <= v_ff[k-1];
         end
         f_ff[k] <= f_ff[k-1];
         rx_ff[k] <= rx_in;
         ry_ff[k] <= ry_in;
         nx_ff[k] <= qx_in;
         ny_ff[k] <= qy_in;
         side_ff[k] <= side_ff[k-1];
      end
   end

   // The low bits of the numerator words have been replaced by quotient bits.
   assign out_valid = v_ff[N-1];
   assign fine_out = f_ff[N-1];
   assign qx_out = nx_ff[N-1][QW-1:0];
   assign qy_out = ny_ff[N-1][QW-1:0];
   assign side_out = side_ff[N-1];
endmodule

[rtl/circle_pair_collision_manifold_unit.sv]
// Top level of the circle pair collision unit with contact manifold.
// Depends on cpcm_pkg, cpcm_front, cpcm_sqrt and cpcm_div.
//
// Usage: drive a pair of circles on the req_ ports and raise start for one
// cycle; the request is taken at that edge, since busy is held low and a new
// request may follow in every cycle. Each request gives exactly one result,
// shown on the rsp_ ports for a single cycle while rsp_valid is high.
// Throughput is one pair per cycle; a request passes three front-end stages
// (differences, squares, overlap test), 31 square root stages at one root
// bit each, 16 divider stages for the normal (one seeding stage and one
// quotient bit each) and an output register. The receiver cannot hold results
// off, so results simply leave in request order. Synchronous reset clears the
// valid bits of every stage, discarding requests in flight; the data
// registers are not reset.
// A pair whose masks share a bit, or whose circles do not touch, gives hit low
// and zero fields. Coincident centres give the radius of a and normal (1,0).
`timescale 1ns / 1ps
module circle_pair_collision_manifold_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [cpcm_pkg::POS_W-1:0]      req_a_pos_x,
   input  logic signed [cpcm_pkg::POS_W-1:0]      req_a_pos_y,
   input  logic [cpcm_pkg::RAD_W-1:0]             req_a_radius,
   input  logic [cpcm_pkg::MASK_BITS-1:0]         req_a_exclude_mask,
   input  logic signed [cpcm_pkg::POS_W-1:0]      req_b_pos_x,
   input  logic signed [cpcm_pkg::POS_W-1:0]      req_b_pos_y,
   input  logic [cpcm_pkg::RAD_W-1:0]             req_b_radius,
   input  logic [cpcm_pkg::MASK_BITS-1:0]         req_b_exclude_mask,
   output logic                                   rsp_valid,
   output logic                                   rsp_hit,
   output logic [cpcm_pkg::PEN_W-1:0]             rsp_penetration,
   output logic signed [cpcm_pkg::NORM_W-1:0]     rsp_normal_x,
   output logic signed [cpcm_pkg::NORM_W-1:0]     rsp_normal_y
);
   logic                          fr_valid, sq_valid, dv_valid;
   logic [cpcm_pkg::SQ_IN_W-1:0]  fr_d2;
   cpcm_pkg::side_type            fr_side, sq_side, dv_side;
   logic [cpcm_pkg::ROOT_W-1:0]   sq_root, dv_fine;
   logic [cpcm_pkg::Q_W-1:0]      dv_qx, dv_qy;

   logic                          valid_ff;
   logic                          hit_ff, hit_in;
   logic [cpcm_pkg::PEN_W-1:0]    pen_ff, pen_in;
   logic [cpcm_pkg::NORM_W-1:0]   nx_ff, nx_in, ny_ff, ny_in;
   logic [cpcm_pkg::ROOT_W-1:0]   coarse;
   logic [cpcm_pkg::NORM_W-1:0]   mag_x, mag_y;

   assign busy = 1'b0;

   cpcm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .a_x       (req_a_pos_x),
      .a_y       (req_a_pos_y),
      .a_r       (req_a_radius),
      .a_m       (req_a_exclude_mask),
      .b_x       (req_b_pos_x),
      .b_y       (req_b_pos_y),
      .b_r       (req_b_radius),
      .b_m       (req_b_exclude_mask),
      .out_valid (fr_valid),
      .d2_out    (fr_d2),
      .side_out  (fr_side)
   );

   cpcm_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .d2_in     (fr_d2),
      .side_in   (fr_side),
      .out_valid (sq_valid),
      .root_out  (sq_root),
      .side_out  (sq_side)
   );

   cpcm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .fine_in   (sq_root),
      .side_in   (sq_side),
      .out_valid (dv_valid),
      .fine_out  (dv_fine),
      .qx_out    (dv_qx),
      .qy_out    (dv_qy),
      .side_out  (dv_side)
   );

   // Distance rounded to the nearest Q.0 step, a whole unit.
   assign coarse = cpcm_pkg::ROOT_W'(({1'b0, dv_fine} + 32'd8192) >> 14);
   assign mag_x = {1'b0, dv_qx};
   assign mag_y = {1'b0, dv_qy};

   always_comb begin
      hit_in = dv_side.hit;
      pen_in = '0;
      nx_in = '0;
      ny_in = '0;
      if (dv_side.hit && dv_side.zero) begin
         pen_in = {1'b0, dv_side.ar};
         nx_in = cpcm_pkg::NORM_ONE;
      end else if (dv_side.hit) begin
         pen_in = dv_side.rs - cpcm_pkg::PEN_W'(coarse);
         nx_in = dv_side.neg_x ? -mag_x : mag_x;
         ny_in = dv_side.neg_y ? -mag_y : mag_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= dv_valid;
      end
      hit_ff <= hit_in;
      pen_ff <= pen_in;
      nx_ff <= nx_in;
      ny_ff <= ny_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_hit = hit_ff;
   assign rsp_penetration = pen_ff;
   assign rsp_normal_x = nx_ff;
   assign rsp_normal_y = ny_ff;

   a_result_follows_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, cpcm_pkg::LATENCY))
      else $error("result without a matching request");
   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |->
         (rsp_penetration == '0 && rsp_normal_x == '0 && rsp_normal_y == '0))
      else $error("miss carries non-zero manifold fields");
   a_normal_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_x <= 16384 && rsp_normal_x >= -16384 &&
                     rsp_normal_y <= 16384 && rsp_normal_y >= -16384))
      else $error("normal component exceeds unit length");
endmodule

[tb/circle_pair_collision_manifold_unit_test.sv]
// Self-checking testbench for the circle pair collision unit.
// Depends on cpcm_pkg and circle_pair_collision_manifold_unit; predicts each result itself.
`timescale 1ns / 1ps
module circle_pair_collision_manifold_unit_test;

   typedef struct {
      logic                        hit;
      logic [cpcm_pkg::PEN_W-1:0]  pen;
      logic [cpcm_pkg::NORM_W-1:0] nx;
      logic [cpcm_pkg::NORM_W-1:0] ny;
   } contact_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [cpcm_pkg::POS_W-1:0] ax = 0, ay = 0, bx = 0, by = 0;
   logic [cpcm_pkg::RAD_W-1:0] ar = 0, br = 0;
   logic [cpcm_pkg::MASK_BITS-1:0] am = 0, bm = 0;
   logic rsp_valid, rsp_hit;
   logic [cpcm_pkg::PEN_W-1:0] rsp_pen;
   logic signed [cpcm_pkg::NORM_W-1:0] rsp_nx, rsp_ny;

   contact_type expected_contacts[$];
   int mismatches = 0;
   int results_seen = 0;
   int hits_seen = 0;
   int idle_cycles = 0;
   localparam int WATCHDOG = 20000;

   circle_pair_collision_manifold_unit u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_pos_x(ax), .req_a_pos_y(ay), .req_a_radius(ar), .req_a_exclude_mask(am),
      .req_b_pos_x(bx), .req_b_pos_y(by), .req_b_radius(br), .req_b_exclude_mask(bm),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_penetration(rsp_pen),
      .rsp_normal_x(rsp_nx), .rsp_normal_y(rsp_ny)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits >>= 2;
      while (bits != 0) begin
         if (v >= res + bits) begin
            v -= res + bits;
            res = (res >> 1) + bits;
         end else begin
            res >>= 1;
         end
         bits >>= 2;
      end
      return res;
   endfunction

   function automatic logic [cpcm_pkg::NORM_W-1:0] unit_axis(longint d, longint unsigned f);
      longint unsigned mag;
      mag = (((d < 0) ? -d : d) << cpcm_pkg::FINE_SHIFT) + (f >> 1);
      mag = mag / f;
      if (mag > 16384) mag = 16384;
      if (d > 0) return cpcm_pkg::NORM_W'(-mag);
      return cpcm_pkg::NORM_W'(mag);
   endfunction

   function automatic contact_type predict_contact();
      contact_type c;
      longint dx, dy;
      longint unsigned d2, rs, fine, coarse;
      c = '{hit: 0, pen: 0, nx: 0, ny: 0};
      if ((am & bm) != 0) return c;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      d2 = dx * dx + dy * dy;
      rs = ar + br;
      if (d2 > rs * rs) return c;
      c.hit = 1;
      if (d2 == 0) begin
         c.pen = {1'b0, ar};
         c.nx = cpcm_pkg::NORM_ONE;
         return c;
      end
      fine = int_sqrt(d2 << cpcm_pkg::FINE_SHIFT);
      coarse = (fine + (64'd1 << 13)) >> 14;
      c.pen = cpcm_pkg::PEN_W'(rs - coarse);
      c.nx = unit_axis(dx, fine);
      c.ny = unit_axis(dy, fine);
      return c;
   endfunction

   // Results are sampled at the rising edge that ends their cycle.
   always @(posedge clock) begin
      contact_type e;
      if (!reset) begin
         if (start && !busy) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid) begin
            results_seen++;
            if (rsp_hit) hits_seen++;
            if (expected_contacts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
               e = expected_contacts.pop_front();
               if (e.hit !== rsp_hit || e.pen !== rsp_pen || e.nx !== rsp_nx
                   || e.ny !== rsp_ny) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp hit %0b pen %0d n %0d,%0d got %0b %0d %0d,%0d",
                              e.hit, e.pen, $signed(e.nx), $signed(e.ny),
                              rsp_hit, rsp_pen, rsp_nx, rsp_ny);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Start is lowered only when there really is a pause, so that it is never
   // driven twice at the same falling edge.
   task automatic random_gap();
      int n;
      n = $urandom_range(0, 99);
      if (n < 60) n = 0;
      else if (n < 95) n = $urandom_range(1, 3);
      else n = $urandom_range(10, 60);
      if (n != 0) begin
         start <= 0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Drives one request and holds it until the accepting edge.
   task automatic send_pair(logic signed [cpcm_pkg::POS_W-1:0] pax, pay,
                            logic [cpcm_pkg::RAD_W-1:0] par,
                            logic [cpcm_pkg::MASK_BITS-1:0] pam,
                            logic signed [cpcm_pkg::POS_W-1:0] pbx, pby,
                            logic [cpcm_pkg::RAD_W-1:0] pbr,
                            logic [cpcm_pkg::MASK_BITS-1:0] pbm);
      ax <= pax; ay <= pay; ar <= par; am <= pam;
      bx <= pbx; by <= pby; br <= pbr; bm <= pbm;
      start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_contacts.insert(expected_contacts.size(), predict_contact());
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 0;
      while (expected_contacts.size() != 0) @(negedge clock);
      repeat (cpcm_pkg::LATENCY + 4) @(negedge clock);
   endtask

   task automatic test_directed();
      send_pair(0, 0, 0, 0, 0, 0, 0, 0);
      send_pair(100, 200, 50, 0, 100, 200, 70, 0);
      send_pair(0, 0, 256, 1, 100, 0, 256, 1);
      send_pair(0, 0, 256, 16'hFFFF, 100, 0, 256, 16'h0000);
      send_pair(0, 0, 256, 16'hAAAA, 100, 0, 256, 16'h5555);
      send_pair(0, 0, 100, 0, 200, 0, 100, 0);
      send_pair(0, 0, 100, 0, 201, 0, 100, 0);
      send_pair(0, 0, 300, 0, 0, 400, 200, 0);
      send_pair(0, 0, 16'hFFFF, 0, 24'sh7FFFFF, 0, 16'hFFFF, 0);
      send_pair(24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF, 0, 24'sh7FFFFF - 70000,
                24'sh7FFFFF - 70000, 16'hFFFF, 0);
      send_pair(-24'sd8388608, -24'sd8388608, 16'hFFFF, 0, -24'sd8388608 + 90000,
                -24'sd8388608 + 3, 16'hFFFF, 0);
      send_pair(-24'sd8388608, 0, 16'hFFFF, 0, 24'sh7FFFFF, 0, 16'hFFFF, 0);
      send_pair(0, 0, 16'hFFFF, 16'h8000, 1, 1, 16'hFFFF, 16'h7FFF);
      send_pair(5, -7, 0, 0, 5, -7, 0, 0);
      send_pair(0, 0, 1, 0, 1, 1, 1, 0);
      send_pair(-3, 0, 2, 0, 0, 0, 1, 0);
      send_pair(0, 9, 2, 0, 0, 0, 10, 0);
   endtask

   task automatic test_random_pairs(int count);
      logic signed [cpcm_pkg::POS_W-1:0] px, py;
      logic [cpcm_pkg::RAD_W-1:0] ra, rb;
      int reach;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) drain();
         ra = cpcm_pkg::RAD_W'($urandom);
         rb = cpcm_pkg::RAD_W'($urandom);
         if ($urandom_range(0, 9) < 2) begin ra = ra & 16'h00FF; rb = rb & 16'h00FF; end
         px = cpcm_pkg::POS_W'($urandom);
         py = cpcm_pkg::POS_W'($urandom);
         reach = ra + rb + 8;
         // Most pairs are placed near each other so that hits are common.
         if ($urandom_range(0, 9) < 8)
            send_pair(px, py, ra, ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0,
                      cpcm_pkg::POS_W'(px + $signed($urandom_range(0, 2 * reach)) - reach),
                      cpcm_pkg::POS_W'(py + $signed($urandom_range(0, 2 * reach)) - reach),
                      rb, 16'($urandom));
         else
            send_pair(px, py, ra, 16'($urandom), 24'($urandom), 24'($urandom), rb,
                      ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'h0);
         if ($urandom_range(0, 2) != 0) random_gap();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      test_directed();
      drain();
      test_random_pairs(1800);
      drain();
      $display("Ran %0d results, %0d hits, directed edges and random pairs.",
               results_seen, hits_seen);
      if (mismatches == 0 && expected_contacts.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
